>>> hw/rtl/gpod_pkg.sv
`default_nettype none

package gpod_pkg;

	localparam int COLOUR_W = 32;
	localparam int GRAY_W   = 8;
	localparam int IDX_W    = 8;
	localparam int COUNT_W  = 9;
	localparam int BAYER_W  = 4;
	localparam int DIFF_W   = 16;

	// item kinds
	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_PIXEL   = 1'b1;

	// register index (paddr[2])
	localparam logic REG_COLOUR_COUNT = 1'b0;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

	// pixel context carried from the read stage into the decision stage
	typedef struct packed {
		logic [IDX_W-1:0]    idx;
		logic [GRAY_W-1:0]   red;
		logic [COLOUR_W-1:0] colour;
		logic [BAYER_W-1:0]  bayer;
		logic                at_low;
		logic                at_high;
	} ctx_t;

	// registered read data of the palette stores
	typedef struct packed {
		logic [COLOUR_W-1:0] colour;
		logic [GRAY_W-1:0]   gray;
		logic [GRAY_W-1:0]   gray_prev;
		logic [GRAY_W-1:0]   gray_next;
	} rd_t;

	// 4x4 bayer threshold in sixteenths
	function automatic logic [BAYER_W-1:0] bayer_lookup(input logic [1:0] y, input logic [1:0] x);
		logic [BAYER_W-1:0] v;
		unique case ({y, x})
			4'b00_00: v = 4'd0;
			4'b00_01: v = 4'd8;
			4'b00_10: v = 4'd2;
			4'b00_11: v = 4'd10;
			4'b01_00: v = 4'd12;
			4'b01_01: v = 4'd4;
			4'b01_10: v = 4'd14;
			4'b01_11: v = 4'd6;
			4'b10_00: v = 4'd3;
			4'b10_01: v = 4'd11;
			4'b10_10: v = 4'd1;
			4'b10_11: v = 4'd9;
			4'b11_00: v = 4'd15;
			4'b11_01: v = 4'd7;
			4'b11_10: v = 4'd13;
			4'b11_11: v = 4'd5;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gpod_store.sv
`default_nettype none

module gpod_store import gpod_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256,
	localparam int AW = $clog2(PALETTE_ENTRIES)
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire logic [COLOUR_W-1:0] wr_colour,
	input  wire logic [GRAY_W-1:0]   wr_gray,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	input  wire logic [AW-1:0]       rd_addr_prev,
	input  wire logic [AW-1:0]       rd_addr_next,
	output rd_t                      rd_q
);

	// entry store: colour and gray at the pixel index
	logic [COLOUR_W+GRAY_W-1:0] entry_mem [PALETTE_ENTRIES];
	// gray copy with two read ports for the neighbors
	logic [GRAY_W-1:0]          gray_mem  [PALETTE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= {wr_colour, wr_gray};
			gray_mem[wr_addr]  <= wr_gray;
		end
		if (rd_en) begin
			{rd_q.colour, rd_q.gray} <= entry_mem[rd_addr];
			rd_q.gray_prev           <= gray_mem[rd_addr_prev];
			rd_q.gray_next           <= gray_mem[rd_addr_next];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/gpod_decide.sv
`default_nettype none

module gpod_decide import gpod_pkg::*; (
	input  wire ctx_t              ctx,
	input  wire rd_t               rd,
	output logic [IDX_W-1:0]       new_index
);

	logic                     down;
	logic                     keep;
	logic                     at_end;
	logic                     below;
	logic                     take;
	logic [GRAY_W-1:0]        lower;
	logic [GRAY_W-1:0]        upper;
	logic signed [GRAY_W+1:0] num;
	logic signed [GRAY_W+1:0] den;
	logic signed [DIFF_W-1:0] num_x;
	logic signed [DIFF_W-1:0] den_x;
	logic signed [DIFF_W-1:0] bay_x;
	logic signed [DIFF_W-1:0] prod;
	logic signed [DIFF_W-1:0] diff;

	always_comb begin
		keep   = (ctx.colour[COLOUR_W-1 -: 8] == 8'd0) || (ctx.colour == rd.colour);
		down   = rd.gray > ctx.red;
		at_end = down ? ctx.at_low : ctx.at_high;
		// pick the gray interval the pixel falls into
		lower  = down ? rd.gray_prev : rd.gray;
		upper  = down ? rd.gray : rd.gray_next;
		num    = $signed({2'b00, ctx.red}) - $signed({2'b00, lower});
		den    = $signed({2'b00, upper}) - $signed({2'b00, lower});
		num_x  = DIFF_W'(num);
		den_x  = DIFF_W'(den);
		bay_x  = $signed({{(DIFF_W-BAYER_W){1'b0}}, ctx.bayer});
		prod   = den_x * bay_x;
		diff   = (num_x <<< 4) - prod;
		// num/den < bayer/16, sign of den flips the test
		below  = (den > 0) ? (diff < 0) : (diff > 0);
		take   = (den == 0) || (down ? below : !below);
		if (keep || at_end || !take) begin
			new_index = ctx.idx;
		end else if (down) begin
			new_index = ctx.idx - IDX_W'(1);
		end else begin
			new_index = ctx.idx + IDX_W'(1);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/gray_palette_ordered_dither_top.sv
// a pixel's result reaches out_index through the palette read register and then the output register
// throughput: one item per cycle, palette writes and pixels alike, while out_ready does not stall the pipe
// rate set by the two-stage pipe: palette read stage, then decision and output register
// reset clears pipeline valids and sets colour_count to 256; palette stores are not cleared
// and an entry reads as garbage until written
`default_nettype none

module gray_palette_ordered_dither_top import gpod_pkg::*; #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// item channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               kind,
	input  wire logic [7:0]         slot,
	input  wire logic [7:0]         entry_gray,
	input  wire logic [1:0]         x_phase,
	input  wire logic [1:0]         y_phase,
	input  wire logic [7:0]         pixel_index,
	input  wire logic [7:0]         blue,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         red,
	input  wire logic [7:0]         alpha,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              out_index,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:2]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [COUNT_W-1:0] colour_count_q;
	logic [COUNT_W-1:0] count_eff;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   idx_clamped;
	logic               in_xfer;
	logic               wr_en;
	logic               adv_out;
	ctx_t               ctx_in;
	ctx_t               ctx_s1;
	logic               valid_s1;
	rd_t                rd_q;
	logic [IDX_W-1:0]   new_index;
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_index_q;

	// register port, no wait states
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_COLOUR_COUNT) begin
			colour_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_COLOUR_COUNT) begin
			prdata = 32'(colour_count_q);
		end
	end

	// effective palette size: zero acts as one, saturate at store depth
	always_comb begin
		if (colour_count_q == '0) begin
			count_eff = COUNT_W'(1);
		end else if (colour_count_q > COUNT_W'(PALETTE_ENTRIES)) begin
			count_eff = COUNT_W'(PALETTE_ENTRIES);
		end else begin
			count_eff = colour_count_q;
		end
		last_idx    = IDX_W'(count_eff - COUNT_W'(1));
		// indices past the palette fall back to the last entry
		idx_clamped = ({1'b0, pixel_index} >= count_eff) ? last_idx : pixel_index;
	end

	// the read stage moves whenever the decision stage can hand off
	assign adv_out  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv_out;
	assign in_xfer  = in_valid && in_ready;

	// palette writes beyond the store depth are dropped
	assign wr_en = in_xfer && kind == KIND_PALETTE && ({1'b0, slot} < COUNT_W'(PALETTE_ENTRIES));

	always_comb begin
		ctx_in.idx     = idx_clamped;
		ctx_in.red     = red;
		ctx_in.colour  = {alpha, red, green, blue};
		ctx_in.bayer   = bayer_lookup(y_phase, x_phase);
		ctx_in.at_low  = idx_clamped == '0;
		ctx_in.at_high = idx_clamped == last_idx;
	end

	// palette stores; a write and a later pixel never share an edge, so the
	// next-cycle read already sees the new entry
	gpod_store #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_store (
		.clk          (clk),
		.wr_en        (wr_en),
		.wr_addr      (AW'(slot)),
		.wr_colour    ({alpha, red, green, blue}),
		.wr_gray      (entry_gray),
		.rd_en        (in_ready),
		.rd_addr      (AW'(idx_clamped)),
		.rd_addr_prev (AW'(idx_clamped - IDX_W'(1))),
		.rd_addr_next (AW'(idx_clamped + IDX_W'(1))),
		.rd_q         (rd_q)
	);

	// stage 1: pixel context alongside the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && kind == KIND_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			ctx_s1 <= ctx_in;
		end
	end

	// threshold compare against the bayer matrix
	gpod_decide u_decide (
		.ctx       (ctx_s1),
		.rd        (rd_q),
		.new_index (new_index)
	);

	// output register, parts the result side from the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			out_index_q <= new_index;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;

	// a pixel leaving stage 1 always lands in the output register
	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_ready |=> out_valid_q)
		else $error("pixel lost between stage 1 and output");

	// a palette write never produces a result
	a_palette_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_PALETTE |=> !valid_s1)
		else $error("palette write entered the result path");

	// a stalled pixel keeps its context
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_ready |=> valid_s1 && $stable(ctx_s1))
		else $error("stage 1 changed while stalled");

endmodule

`default_nettype wire

>>> tb/sv/gray_palette_ordered_dither_top_tb.sv
module gray_palette_ordered_dither_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gpod_pkg::*;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          SETTLE      = 4;     // margin for the pipe to empty after the last result
	localparam int          LONG_HOLD   = 300;
	localparam int          PHASES      = 9;
	localparam int          PHASE_ITEMS = 180;
	localparam logic [2:2]  REG_SPARE   = 1'b1;  // no register behind this address

	// one item on the input channel
	typedef struct {
		logic       kind;
		logic [7:0] slot;
		logic [7:0] entry_gray;
		logic [1:0] x_phase;
		logic [1:0] y_phase;
		logic [7:0] pixel_index;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} dither_item_t;

	// mirrors the palette and the count, keeps the dithered indices still owed
	class dither_checker;
		logic [31:0] pal_colour [256];
		logic [7:0]  pal_gray [256];
		logic [8:0]  count_reg;
		logic [7:0]  index_q [$];
		int unsigned thr [16];
		int          failures;

		function new();
			count_reg = COUNT_RESET;
			thr = '{0, 8, 2, 10, 12, 4, 14, 6, 3, 11, 1, 9, 15, 7, 13, 5};
			failures = 0;
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10)
				$display("%s", msg);
		endfunction

		function int outstanding();
			return index_q.size();
		endfunction

		// count as the block uses it: zero acts as one, above the store saturates
		function int active_entries();
			if (count_reg == 0)
				return 1;
			if (count_reg > 256)
				return 256;
			return int'(count_reg);
		endfunction

		// true when num/den lies below b/16, compared without division
		function bit below_threshold(int num, int den, int b);
			int diff;
			diff = 16 * num - b * den;
			if (den > 0)
				return diff < 0;
			return diff > 0;
		endfunction

		function logic [7:0] dithered_index(dither_item_t it);
			int          n, idx, res, bv, gp, go, gn;
			logic [31:0] colour;
			n = active_entries();
			idx = it.pixel_index;
			if (idx >= n)
				idx = n - 1;
			res = idx;
			bv = thr[{it.y_phase, it.x_phase}];
			colour = {it.alpha, it.red, it.green, it.blue};
			if (it.alpha != 8'd0 && colour != pal_colour[idx]) begin
				gp = pal_gray[idx];
				go = it.red;
				if (gp > go) begin
					if (idx != 0) begin
						gn = pal_gray[idx - 1];
						if (gp == gn || below_threshold(go - gn, gp - gn, bv))
							res = idx - 1;
					end
				end else if (idx != n - 1) begin
					gn = pal_gray[idx + 1];
					if (gp == gn || !below_threshold(go - gp, gn - gp, bv))
						res = idx + 1;
				end
			end
			return 8'(res);
		endfunction

		function void note_item(dither_item_t it);
			if (it.kind == KIND_PALETTE) begin
				pal_colour[it.slot] = {it.alpha, it.red, it.green, it.blue};
				pal_gray[it.slot] = it.entry_gray;
			end else begin
				index_q.push_back(dithered_index(it));
			end
		endfunction

		function void check_index(logic [7:0] got);
			logic [7:0] want;
			if (index_q.size() == 0) begin
				flag($sformatf("out_index %0d arrived with no pixel pending", got));
				return;
			end
			want = index_q.pop_front();
			if (got !== want)
				flag($sformatf("out_index mismatch: expected %0d, got %0d", want, got));
		endfunction
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic        kind        = 1'b0;
	logic [7:0]  slot        = '0;
	logic [7:0]  entry_gray  = '0;
	logic [1:0]  x_phase     = '0;
	logic [1:0]  y_phase     = '0;
	logic [7:0]  pixel_index = '0;
	logic [7:0]  blue        = '0;
	logic [7:0]  green       = '0;
	logic [7:0]  red         = '0;
	logic [7:0]  alpha       = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [7:0]  out_index;
	logic        psel        = 1'b0;
	logic        penable     = 1'b0;
	logic        pwrite      = 1'b0;
	logic [2:2]  paddr       = '0;
	logic [31:0] pwdata      = '0;
	logic [31:0] prdata;
	logic        pready;

	dither_checker dither_chk;

	// knobs shared by the stimulus and the result sink
	bit sink_stalls   = 1'b0;
	bit long_hold_req = 1'b0;

	gray_palette_ordered_dither_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.slot       (slot),
		.entry_gray (entry_gray),
		.x_phase    (x_phase),
		.y_phase    (y_phase),
		.pixel_index(pixel_index),
		.blue       (blue),
		.green      (green),
		.red        (red),
		.alpha      (alpha),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_index  (out_index),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one transfer on the item channel; valid stays up until in_ready is seen
	task automatic offer_item(input dither_item_t it);
		@(negedge clk);
		in_valid    <= 1'b1;
		kind        <= it.kind;
		slot        <= it.slot;
		entry_gray  <= it.entry_gray;
		x_phase     <= it.x_phase;
		y_phase     <= it.y_phase;
		pixel_index <= it.pixel_index;
		blue        <= it.blue;
		green       <= it.green;
		red         <= it.red;
		alpha       <= it.alpha;
		do @(posedge clk); while (!in_ready);
		dither_chk.note_item(it);
	endtask

	// sender gap: in_valid stays low for a span set by n
	task automatic idle_input(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// stop offering, wait for every owed result, then let the pipe empty
	// (palette writes leave nothing behind to wait on)
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (dither_chk.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// setup cycle, then access cycle; the transfer lands where pready is high
	task automatic apb_access(input logic wr, input logic [2:2] addr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic confirm_count();
		logic [31:0] rd;
		apb_access(1'b0, REG_COLOUR_COUNT, '0, rd);
		if (rd[8:0] !== dither_chk.count_reg)
			dither_chk.flag($sformatf("colour_count readback: expected %0d, got %0d",
				dither_chk.count_reg, rd[8:0]));
	endtask

	task automatic program_count(input int unsigned value);
		logic [31:0] rd;
		apb_access(1'b1, REG_COLOUR_COUNT, 32'(value), rd);
		dither_chk.count_reg = 9'(value);
		confirm_count();
	endtask

	function automatic dither_item_t palette_at(input int idx, input int gray);
		dither_item_t it;
		it.kind        = KIND_PALETTE;
		it.slot        = 8'(idx);
		it.entry_gray  = 8'(gray);
		it.x_phase     = 2'($urandom);
		it.y_phase     = 2'($urandom);
		it.pixel_index = 8'($urandom);
		it.blue        = 8'($urandom);
		it.green       = 8'($urandom);
		it.red         = 8'($urandom);
		it.alpha       = 8'($urandom);
		return it;
	endfunction

	function automatic dither_item_t pixel_at(input int idx, input int gray, input int x,
			input int y);
		dither_item_t it;
		it = palette_at(0, 0);
		it.kind        = KIND_PIXEL;
		it.slot        = 8'($urandom);
		it.entry_gray  = 8'($urandom);
		it.pixel_index = 8'(idx);
		it.red         = 8'(gray);
		it.x_phase     = 2'(x);
		it.y_phase     = 2'(y);
		it.alpha       = 8'($urandom_range(1, 255));
		return it;
	endfunction

	// mostly pixels whose gray falls around their entry and its neighbors,
	// some exact palette colours, some transparent, some indices past the count;
	// palette rewrites mostly keep the order, now and then break it
	function automatic dither_item_t random_item();
		dither_item_t it;
		int           n, c, lo, hi, g, pick;
		it = palette_at($urandom_range(0, 255), $urandom_range(0, 255));
		n = dither_chk.active_entries();
		if ($urandom_range(0, 9) == 0) begin
			if ($urandom_range(0, 9) < 7) begin
				lo = (it.slot == 8'd0) ? 0 : dither_chk.pal_gray[it.slot - 1];
				hi = (it.slot == 8'd255) ? 255 : dither_chk.pal_gray[it.slot + 1];
				it.entry_gray = 8'($urandom_range(lo, hi));
			end
			return it;
		end
		it.kind = KIND_PIXEL;
		c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, n - 1);
		it.pixel_index = 8'(c);
		if (c >= n)
			c = n - 1;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			it.alpha = 8'd0;
		end else if (pick == 1) begin
			{it.alpha, it.red, it.green, it.blue} = dither_chk.pal_colour[c];
		end else if (pick < 9) begin
			lo = dither_chk.pal_gray[c];
			hi = lo;
			if (c > 0) begin
				g = dither_chk.pal_gray[c - 1];
				if (g < lo) lo = g;
				if (g > hi) hi = g;
			end
			if (c < n - 1) begin
				g = dither_chk.pal_gray[c + 1];
				if (g < lo) lo = g;
				if (g > hi) hi = g;
			end
			it.red = 8'($urandom_range((hi < 253) ? hi + 2 : 255, (lo > 2) ? lo - 2 : 0));
		end
		return it;
	endfunction

	// result sink: random stall bursts, plus one long hold-off on request
	initial begin : result_sink
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 15);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// every result transfer is checked against the oldest owed index
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			dither_chk.check_index(out_index);
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		dither_item_t it;
		int unsigned  plan [PHASES];
		int           patch [8];
		int           p, k, g;
		bit           source_gaps;
		logic [31:0]  rd;

		dither_chk = new();
		plan = '{256, 1, 0, 2, 17, 300, 511, 255, 256};
		// ties at 0/1 and 3/4, an unsorted tail with a gray-zero last entry
		patch = '{40, 40, 100, 200, 200, 150, 255, 0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		confirm_count();

		// fill the whole store first so no pixel ever reads an unwritten entry;
		// gray ramp with random steps of 0..2 gives ties and gaps
		g = $urandom_range(0, 8);
		for (k = 0; k < 256; k++) begin
			offer_item(palette_at(k, g));
			g = g + $urandom_range(0, 2);
			if (g > 255)
				g = 255;
		end

		// directed pixels over a small hand-made palette
		foreach (patch[i])
			offer_item(palette_at(i, patch[i]));
		drain_results();
		program_count(8);
		it = pixel_at(2, 0, 0, 0);
		it.alpha = 8'd0;                         // transparent keeps its index
		offer_item(it);
		it = pixel_at(2, 0, 3, 3);
		{it.alpha, it.red, it.green, it.blue} = dither_chk.pal_colour[2];
		offer_item(it);                          // exact palette colour
		offer_item(pixel_at(0, 0, 0, 0));        // darker at the bottom entry
		offer_item(pixel_at(7, 255, 3, 3));      // brighter at the top entry
		offer_item(pixel_at(1, 0, 1, 2));        // darker, lower neighbor same gray
		offer_item(pixel_at(3, 255, 2, 1));      // brighter, upper neighbor same gray
		offer_item(pixel_at(2, 70, 1, 0));       // halfway down, threshold 8/16
		offer_item(pixel_at(2, 70, 3, 0));       // halfway down, threshold 10/16
		offer_item(pixel_at(2, 150, 1, 0));      // halfway up, threshold 8/16
		offer_item(pixel_at(2, 150, 3, 0));      // halfway up, threshold 10/16
		offer_item(pixel_at(200, 0, 2, 2));      // index past the count
		offer_item(pixel_at(255, 255, 0, 3));
		offer_item(pixel_at(2, 10, 0, 0));       // below the lower neighbor
		offer_item(pixel_at(4, 210, 1, 1));      // upper neighbor darker
		offer_item(pixel_at(5, 100, 2, 3));      // lower neighbor brighter
		offer_item(pixel_at(6, 255, 0, 0));
		it = pixel_at(6, 254, 0, 3);
		it.alpha = 8'd255;
		offer_item(it);

		// random phases across count settings; the last one runs without idling
		for (p = 0; p < PHASES; p++) begin
			drain_results();
			if (p == 3)
				apb_access(1'b1, REG_SPARE, $urandom, rd);
			program_count(plan[p]);
			source_gaps = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			sink_stalls = (p == 0) || ((p != PHASES - 1) && ($urandom_range(0, 3) != 0));
			// sink holds off while the sender keeps offering back to back
			if (p == 0)
				long_hold_req = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				// in phase 4 the sender waits out every owed result mid-phase
				if (p == 4 && k == PHASE_ITEMS / 2)
					drain_results();
				if (source_gaps && !(p == 0 && k < 80) && $urandom_range(0, 5) == 0)
					idle_input($urandom_range(1, 16));
				offer_item(random_item());
			end
		end
		drain_results();

		if (dither_chk.failures == 0 && dither_chk.outstanding() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
